>>> design/battery_state_of_charge_assert.svh
// ----------------------------------------------------------------------------
// Battery state-of-charge assertion macros
// Shared concurrent assertion forms for the state-of-charge checker.
// ----------------------------------------------------------------------------
`ifndef BATTERY_STATE_OF_CHARGE_ASSERT_SVH
`define BATTERY_STATE_OF_CHARGE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSOC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("battery_state_of_charge: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BSOC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("battery_state_of_charge: next-cycle check failed");

`endif

>>> design/bsoc_pkg.sv
// ----------------------------------------------------------------------------
// Battery state-of-charge package
// Widths, curve tables, register codes and small helper functions.
// ----------------------------------------------------------------------------
package bsoc_pkg;

  // Fixed-point format of the charge and throughput accumulators.
  localparam int FRAC_BITS  = 24;
  localparam int MAX_CYCLES = 3000;

  // Port field widths.
  localparam int VOLT_W  = 16;
  localparam int CUR_W   = 16;
  localparam int SOC_W   = 18;
  localparam int CYC_W   = 12;
  localparam int HLT_W   = 14;
  localparam int CAP_W   = 10;
  localparam int IDX_W   = 1;
  localparam int IN_W    = VOLT_W + CUR_W;
  localparam int OUT_W   = 48;
  localparam int OUT_PAD = OUT_W - SOC_W - CYC_W - HLT_W;

  // Internal widths.
  localparam int ACC_W   = 48;
  localparam int TP_W    = FRAC_BITS + 8;
  localparam int DIV_N   = (FRAC_BITS + 20 > 46) ? FRAC_BITS + 20 : 46;
  localparam int DVS_W   = 30;
  localparam int CNT_W   = $clog2(DIV_N + 1);
  localparam int SC_W    = ACC_W + 7;
  localparam int NUM_W   = 50;
  localparam int V_W     = 31;
  localparam int VU_W    = 28;
  localparam int PV_W    = 30;
  localparam int PC_W    = 22;
  localparam int SLOPE_W = 20;
  localparam int OFF_W   = 48;
  localparam int HC_W    = 24;
  localparam int HC36_W  = 29;
  localparam int MAG_W   = 16;
  localparam int MAG20_W = 20;
  localparam int MUL_W   = 7;
  localparam int SEG_N   = 5;
  localparam int SEG_IW  = 3;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_MODE     = 1'b0,
    REG_CAPACITY = 1'b1
  } cfg_reg_t;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(100);

  // Open-circuit voltage in 0.1 uV: voltage_mv*10000 - current_ma*54.
  localparam int VOLT_SCALE = 10000;
  localparam int IR_DROP    = 54;

  // Curve limits in 0.1 uV.
  localparam logic signed [V_W-1:0] V_MIN = V_W'(186000000);
  localparam logic signed [V_W-1:0] V_TOP = V_W'(266000000);

  // Segment upper bounds, slopes and offsets. The offsets already carry the
  // half-unit rounding bias of the final divide by 1e9.
  localparam logic [VU_W-1:0] SEG_TOP [SEG_N] = '{
    28'd240000000, 28'd243800000, 28'd245800000, 28'd247800000, 28'd266000000
  };
  localparam logic [SLOPE_W-1:0] SEG_SLOPE [SEG_N] = '{
    20'd32265, 20'd493080, 20'd1012000, 20'd1000000, 20'd94240
  };
  localparam logic [OFF_W-1:0] SEG_OFFSET [SEG_N] = '{
    48'd6087100000000, 48'd116219500000000, 48'd242649500000000,
    48'd239699500000000, 48'd14812500000000
  };

  localparam logic [DVS_W-1:0]       BILLION    = DVS_W'(1000000000);
  localparam logic signed [NUM_W-1:0] BILLION_M1 = NUM_W'(999999999);

  localparam int SOC_TOP     = 10000;
  localparam int SOC_LIMIT   = 100000;
  localparam int HEALTH_FULL = 10000;

  localparam logic signed [SC_W-1:0] SOC_HI  = SC_W'(SOC_LIMIT);
  localparam logic signed [SC_W-1:0] SOC_LO  = -SOC_HI;
  localparam logic [SC_W-1:0]        SC_HALF = SC_W'(1) << (FRAC_BITS - 1);

  localparam logic [TP_W-1:0]  TP_LIMIT = TP_W'(200) << FRAC_BITS;
  localparam logic [MUL_W-1:0] HUNDRED  = MUL_W'(100);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // State of health in 0.01 percent from the cycle count.
  function automatic logic [HLT_W-1:0] health_of(input logic [CYC_W-1:0] c);
    logic [HLT_W-1:0] used;
    used = (HLT_W'(c) << 1) + HLT_W'(c);
    return (used >= HLT_W'(HEALTH_FULL)) ? HLT_W'(1) : HLT_W'(HEALTH_FULL) - used;
  endfunction

  // First curve segment whose upper bound lies above the voltage.
  function automatic logic [SEG_IW-1:0] seg_sel(input logic [VU_W-1:0] vu);
    logic [SEG_IW-1:0] idx;
    idx = SEG_IW'(SEG_N - 1);
    for (int k = SEG_N - 1; k >= 0; k--) begin
      if (vu < SEG_TOP[k]) idx = SEG_IW'(k);
    end
    return idx;
  endfunction

  // Saturate a wide signed result to the reported range.
  function automatic logic [SOC_W-1:0] clamp_soc(input logic signed [SC_W-1:0] s);
    if (s > SOC_HI) return SOC_W'(SOC_LIMIT);
    if (s < SOC_LO) return SOC_W'(-SOC_LIMIT);
    return SOC_W'(s);
  endfunction

endpackage

>>> design/bsoc_div.sv
// ----------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsoc_div import bsoc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_N-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_N-1:0] quotient
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_N-1:0] work_r, work_nxt;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign shifted = {rem_r, work_r[DIV_N-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    work_nxt = work_r;
    if (start) begin
      cnt_nxt  = CNT_W'(DIV_N);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      work_nxt = dividend;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
      rem_nxt  = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      work_nxt = {work_r[DIV_N-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    work_r <= work_nxt;
  end

  assign done     = done_r;
  assign quotient = work_r;

endmodule

>>> design/battery_state_of_charge.sv
// ----------------------------------------------------------------------------
// Battery state-of-charge estimator
// Open-circuit voltage curve or coulomb counting with cycle and health
// tracking, built around one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Channel  Direction  Word contents (low bits first)
// in_      slave      voltage_mv[15:0], current_ma[31:16]
// out_     master     soc_centi[17:0], cycles_done[29:18], health_permyriad[43:30]
// cfg_     slave      cfg_index selects the register, cfg_data carries its value
//
// One word is in work at a time. The bit-serial divider sets the time from
// acceptance to a valid result in both modes, and a voltage that lies off the
// curve bypasses it. The next input word is taken the cycle after a result
// enters the output register, so a stalled output costs at most one finished
// result of slack.
// Reset clears the accumulators and the cycle count and loads capacity 100.
// ----------------------------------------------------------------------------
module battery_state_of_charge import bsoc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // voltage_mv, current_ma
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // soc_centi, cycles_done, health_permyriad
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CAP_W-1:0] cfg_data
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_VOLT   = 11'b000_0000_0010,
    ST_SEG    = 11'b000_0000_0100,
    ST_NUM    = 11'b000_0000_1000,
    ST_LOAD   = 11'b000_0001_0000,
    ST_HEALTH = 11'b000_0010_0000,
    ST_CDIV   = 11'b000_0100_0000,
    ST_DIV    = 11'b000_1000_0000,
    ST_SCALE  = 11'b001_0000_0000,
    ST_ROUND  = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      mode_r, mode_nxt;
  logic [CAP_W-1:0]          cap_r, cap_nxt;
  logic signed [ACC_W-1:0]   charge_r, charge_nxt;
  logic [TP_W-1:0]           tp_r, tp_nxt;
  logic [CYC_W-1:0]          cycles_r, cycles_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]          out_data_r, out_data_nxt;

  logic [VOLT_W-1:0]         volt_r, volt_nxt;
  logic signed [CUR_W-1:0]   cur_r, cur_nxt;
  logic signed [V_W-1:0]     v_r, v_nxt;
  logic [OFF_W-1:0]          prod_r, prod_nxt;
  logic [OFF_W-1:0]          off_r, off_nxt;
  logic signed [NUM_W-1:0]   n_r, n_nxt;
  logic [HC_W-1:0]           hc_r, hc_nxt;
  logic [MAG_W-1:0]          mag_r, mag_nxt;
  logic [SOC_W-1:0]          soc_r, soc_nxt;
  logic signed [SC_W-1:0]    mul_acc_r, mul_acc_nxt;
  logic signed [SC_W-1:0]    mcand_r, mcand_nxt;
  logic [MUL_W-1:0]          mplier_r, mplier_nxt;

  logic                      in_acc;
  logic                      out_free;
  logic [HLT_W-1:0]          health_now;
  logic [CAP_W-1:0]          cap_eff;
  logic [PV_W-1:0]           pv;
  logic signed [PC_W-1:0]    pc;
  logic [VU_W-1:0]           vu;
  logic [SEG_IW-1:0]         seg_idx;
  logic [OFF_W-1:0]          prod_calc;
  logic [DIV_N-1:0]          vdiv_num;
  logic [HC36_W-1:0]         hc36;
  logic [MAG20_W-1:0]        mag20;
  logic [DIV_N-1:0]          cdiv_num;
  logic                      div_start;
  logic [DIV_N-1:0]          div_num;
  logic [DVS_W-1:0]          div_dvs;
  logic                      div_done;
  logic [DIV_N-1:0]          div_quo;
  logic signed [SC_W-1:0]    quo_s;
  logic signed [ACC_W:0]     q_ext;
  logic signed [ACC_W:0]     acc_sum;
  logic signed [ACC_W-1:0]   acc_sat;
  logic [DIV_N:0]            tp_sum;
  logic                      tp_wrap;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign health_now = health_of(cycles_r);
  assign cap_eff    = (cap_r == '0) ? CAP_W'(1) : cap_r;

  // Open-circuit voltage terms.
  assign pv = PV_W'(volt_r) * PV_W'(VOLT_SCALE);
  assign pc = PC_W'(cur_r) * PC_W'(IR_DROP);

  // Curve segment product; only used when the voltage is on the curve.
  assign vu        = v_r[VU_W-1:0];
  assign seg_idx   = seg_sel(vu);
  assign prod_calc = SEG_SLOPE[seg_idx] * vu;

  // Floor division by 1e9 done on the magnitude: a negative numerator is
  // turned into (1e9 - 1 - n) and the quotient negated afterwards.
  assign vdiv_num = n_r[NUM_W-1] ? DIV_N'(BILLION_M1 - n_r) : DIV_N'(n_r);

  // Coulomb step: round(num/div) as (2*num + div) / (2*div), with
  // num = |current|*10 << FRAC_BITS and div = health*capacity*36.
  assign hc36     = (HC36_W'(hc_r) << 5) + (HC36_W'(hc_r) << 2);
  assign mag20    = (MAG20_W'(mag_r) << 4) + (MAG20_W'(mag_r) << 2);
  assign cdiv_num = (DIV_N'(mag20) << FRAC_BITS) + DIV_N'(hc36);

  assign div_start = (state_r == ST_LOAD) || (state_r == ST_CDIV);
  assign div_num   = (state_r == ST_LOAD) ? vdiv_num : cdiv_num;
  assign div_dvs   = (state_r == ST_LOAD) ? BILLION : {hc36, 1'b0};

  bsoc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign quo_s = $signed({{(SC_W-DIV_N){1'b0}}, div_quo});

  // Charge accumulator update with saturation at the signed limits.
  assign q_ext   = $signed((ACC_W+1)'(div_quo));
  assign acc_sum = cur_r[CUR_W-1] ? (ACC_W+1)'(charge_r) - q_ext
                                  : (ACC_W+1)'(charge_r) + q_ext;
  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  // Throughput sum and the 200 percent crossing.
  assign tp_sum  = (DIV_N+1)'(tp_r) + (DIV_N+1)'(div_quo);
  assign tp_wrap = tp_sum >= (DIV_N+1)'(TP_LIMIT);

  // Configuration writes.
  always_comb begin
    mode_nxt = mode_r;
    cap_nxt  = cap_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:     mode_nxt = cfg_data[0];
        REG_CAPACITY: cap_nxt  = cfg_data;
        default:      ;
      endcase
    end
  end

  // Sequencer and datapath.
  always_comb begin
    state_nxt     = state_r;
    charge_nxt    = charge_r;
    tp_nxt        = tp_r;
    cycles_nxt    = cycles_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    volt_nxt      = volt_r;
    cur_nxt       = cur_r;
    v_nxt         = v_r;
    prod_nxt      = prod_r;
    off_nxt       = off_r;
    n_nxt         = n_r;
    hc_nxt        = hc_r;
    mag_nxt       = mag_r;
    soc_nxt       = soc_r;
    mul_acc_nxt   = mul_acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          volt_nxt  = in_tdata[VOLT_W-1:0];
          cur_nxt   = in_tdata[IN_W-1:VOLT_W];
          state_nxt = mode_r ? ST_HEALTH : ST_VOLT;
        end
      end
      ST_VOLT: begin
        v_nxt     = $signed({1'b0, pv}) - V_W'(pc);
        state_nxt = ST_SEG;
      end
      ST_SEG: begin
        if (v_r < V_MIN) begin
          soc_nxt   = '0;
          state_nxt = ST_DONE;
        end else if (v_r >= V_TOP) begin
          soc_nxt   = SOC_W'(SOC_TOP);
          state_nxt = ST_DONE;
        end else begin
          prod_nxt  = prod_calc;
          off_nxt   = SEG_OFFSET[seg_idx];
          state_nxt = ST_NUM;
        end
      end
      ST_NUM: begin
        n_nxt     = $signed({2'b0, prod_r}) - $signed({2'b0, off_r});
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_HEALTH: begin
        hc_nxt    = health_now * cap_eff;
        mag_nxt   = cur_r[CUR_W-1] ? MAG_W'(-cur_r) : MAG_W'(cur_r);
        state_nxt = ST_CDIV;
      end
      ST_CDIV: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (!mode_r) begin
            soc_nxt   = clamp_soc(n_r[NUM_W-1] ? -quo_s : quo_s);
            state_nxt = ST_DONE;
          end else begin
            charge_nxt = acc_sat;
            if (tp_wrap) begin
              tp_nxt = '0;
              if (cycles_r < CYC_W'(MAX_CYCLES)) cycles_nxt = cycles_r + CYC_W'(1);
            end else begin
              tp_nxt = tp_sum[TP_W-1:0];
            end
            // Start the shift-add scaling by 100 with the rounding half loaded.
            mcand_nxt   = SC_W'(acc_sat);
            mul_acc_nxt = SC_HALF;
            mplier_nxt  = HUNDRED;
            state_nxt   = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        if (mplier_r[0]) mul_acc_nxt = mul_acc_r + mcand_r;
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
        if (mplier_r[MUL_W-1:1] == '0) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        soc_nxt   = clamp_soc(mul_acc_r >>> FRAC_BITS);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{OUT_PAD{1'b0}}, health_now, cycles_r, soc_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 1'b0;
      cap_r       <= CAP_RESET;
      charge_r    <= '0;
      tp_r        <= '0;
      cycles_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cap_r       <= cap_nxt;
      charge_r    <= charge_nxt;
      tp_r        <= tp_nxt;
      cycles_r    <= cycles_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    volt_r     <= volt_nxt;
    cur_r      <= cur_nxt;
    v_r        <= v_nxt;
    prod_r     <= prod_nxt;
    off_r      <= off_nxt;
    n_r        <= n_nxt;
    hc_r       <= hc_nxt;
    mag_r      <= mag_nxt;
    soc_r      <= soc_nxt;
    mul_acc_r  <= mul_acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
  end

endmodule

>>> design/bsoc_chk.sv
// ----------------------------------------------------------------------------
// Battery state-of-charge port checker
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
`include "battery_state_of_charge_assert.svh"

module bsoc_chk import bsoc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // Nothing is offered on the result side right after reset.
  `BSOC_ASSERT_NOW(a_reset_quiet, !$past(rst_n), !out_tvalid)

  // A stalled result word holds still.
  `BSOC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // The block is busy again in the cycle after it takes a word.
  `BSOC_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // Reported health and cycle count agree and the count stays in range.
  `BSOC_ASSERT_NOW(a_health_matches, out_tvalid, (out_tdata[29:18] <= CYC_W'(MAX_CYCLES)) && ((16'(out_tdata[43:30]) + 16'(out_tdata[29:18]) * 16'd3) == 16'(HEALTH_FULL)))

endmodule

bind battery_state_of_charge bsoc_chk u_bsoc_chk (.*);
